[design/kmp_stream_matcher_macros.svh]
// ============================================================================
// KMP stream matcher assertion macros
// Shorthand for the concurrent checks used in the design. Each macro expects
// clk and rst_n to be visible where it is used.
// ============================================================================
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kmp_pkg.sv]
// ============================================================================
// KMP package
// Shared types, constants and helpers of the KMP stream matcher.
// ============================================================================
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int KMP_MAX_PATTERN   = 16;
    localparam int KMP_POSITION_BITS = 32;
    localparam int PAT_BYTES         = 16;
    localparam int PAT_BITS          = PAT_BYTES * 8;
    localparam int LEN_W             = 5;
    localparam int KIDX_W            = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int REG_IDX_W         = 2;
    localparam int MATCH_IDX_W       = 32;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_IDX_W-1:0] match_index;
    } res_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]    eff_len;
        logic [PAT_BITS-1:0] pattern;
        logic                rebuild;
    } cfg_bus_t;

    typedef enum logic [1:0] {
        ENG_BUILD,
        ENG_IDLE,
        ENG_WALK
    } eng_state_t;

    function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pattern,
                                            input logic [KIDX_W-1:0]   idx);
        logic [7:0] b;
        b = pattern[{idx, 3'b000} +: 8];
        return b;
    endfunction

endpackage

[design/kmp_queue.sv]
// ============================================================================
// KMP queue
// Small first-in first-out buffer used on the input and the result side.
// ============================================================================
`timescale 1ns / 1ps

module kmp_queue
    import kmp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/kmp_back.sv]
// ============================================================================
// KMP back end
// Builds the failure table from the pattern and runs the matcher over the
// queued text bytes, one comparison or one fallback step per cycle unless a result waits on a full result queue.
// ============================================================================
`timescale 1ns / 1ps
`include "kmp_stream_matcher_macros.svh"

module kmp_back
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = KMP_MAX_PATTERN,
    parameter int POSITION_BITS = KMP_POSITION_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_bus_t  cfg,
    input  in_item_t  head,
    input  logic      head_valid,
    output logic      head_pop,
    input  logic      res_full,
    output logic      res_push,
    output res_item_t res_item
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW1    = POSITION_BITS + 1;
    localparam int WIDE_W = (PW1 > MATCH_IDX_W) ? PW1 : MATCH_IDX_W;

    logic [KIDX_W-1:0] fail_tbl [MAX_PATTERN];

    eng_state_t              state_reg, state_next;
    logic [LEN_W-1:0]        bi_reg, bi_next;
    logic [KIDX_W-1:0]       bk_reg, bk_next;
    logic [KIDX_W-1:0]       work_k_reg, work_k_next;
    logic [7:0]              work_c_reg, work_c_next;
    logic                    work_last_reg, work_last_next;
    logic [LEN_W-1:0]        matched_reg, matched_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                    done_reg, done_next;

    // Builder signals
    logic [7:0]        pk, pi;
    logic              b_fall, build_done, b_step;
    logic [KIDX_W-1:0] bk_new;

    // Shared table port
    logic [KIDX_W-1:0] rd_idx, tbl_rd;
    logic              tbl_we;
    logic [KIDX_W-1:0] tbl_wa, tbl_wd;

    // Matcher signals
    logic                     active, skip, m_fall, commit, hit, emit, eq;
    logic [7:0]               c_cur;
    logic                     last_cur;
    logic [LEN_W-1:0]         k_base, k_new;
    logic [KIDX_W-1:0]        k_cur;
    logic [POSITION_BITS-1:0] pos_cur, pos_sat;
    logic [PW1-1:0]           pos_inc, m_ext, idx_full;
    logic [WIDE_W-1:0]        idx_wide;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        if (cfg.rebuild)
        begin
            state_next = ENG_BUILD;
        end
        else
        begin
            case (state_reg)
                ENG_BUILD:
                begin
                    if (build_done)
                    begin
                        state_next = ENG_IDLE;
                    end
                end
                ENG_IDLE:
                begin
                    // A byte dropped after the result never starts a walk.
                    if (active && !skip && m_fall)
                    begin
                        state_next = ENG_WALK;
                    end
                end
                ENG_WALK:
                begin
                    if (commit)
                    begin
                        state_next = ENG_IDLE;
                    end
                end
                default:
                begin
                    state_next = ENG_BUILD;
                end
            endcase
        end
    end

    // Datapath and outputs
    always_comb
    begin
        // Table builder: bi walks the pattern, bk is the current border length.
        pk         = pat_byte(cfg.pattern, bk_reg);
        pi         = pat_byte(cfg.pattern, bi_reg[KIDX_W-1:0]);
        b_fall     = (bk_reg != '0) && (pk != pi);
        bk_new     = bk_reg + KIDX_W'(pk == pi);
        build_done = (state_reg == ENG_BUILD) && (bi_reg != '0) && (bi_reg >= cfg.eff_len);
        b_step     = (state_reg == ENG_BUILD) && !build_done;

        // Matcher operand selection
        if (state_reg == ENG_WALK)
        begin
            c_cur    = work_c_reg;
            last_cur = work_last_reg;
            k_base   = LEN_W'(work_k_reg);
            k_cur    = work_k_reg;
            pos_cur  = pos_reg;
            skip     = 1'b0;
            active   = 1'b1;
        end
        else
        begin
            c_cur    = head.text_byte;
            last_cur = head.last_byte;
            k_base   = head.first_byte ? '0 : matched_reg;
            // A shortened pattern restarts the partial match.
            k_cur    = (k_base >= cfg.eff_len) ? '0 : k_base[KIDX_W-1:0];
            pos_cur  = head.first_byte ? '0 : pos_reg;
            skip     = !head.first_byte && done_reg;
            active   = (state_reg == ENG_IDLE) && head_valid;
        end

        eq     = (pat_byte(cfg.pattern, k_cur) == c_cur);
        m_fall = (k_cur != '0) && !eq;
        k_new  = LEN_W'(k_cur) + LEN_W'(eq);
        hit    = (k_new == cfg.eff_len);
        emit   = hit || last_cur;
        commit = active && !skip && !m_fall && !(emit && res_full);

        if (state_reg == ENG_BUILD)
        begin
            rd_idx = bk_reg - 1'b1;
        end
        else
        begin
            rd_idx = k_cur - 1'b1;
        end
        tbl_rd = fail_tbl[rd_idx[IDX_W-1:0]];

        tbl_we = 1'b0;
        tbl_wa = bi_reg[KIDX_W-1:0];
        tbl_wd = '0;
        if (b_step)
        begin
            if (bi_reg == '0)
            begin
                tbl_we = 1'b1;
            end
            else if (!b_fall)
            begin
                tbl_we = 1'b1;
                tbl_wd = bk_new;
            end
        end

        pos_sat  = (pos_cur == {POSITION_BITS{1'b1}}) ? pos_cur : pos_cur + 1'b1;
        pos_inc  = PW1'(pos_cur) + 1'b1;
        m_ext    = PW1'(cfg.eff_len);
        idx_full = (pos_inc >= m_ext) ? pos_inc - m_ext : '0;
        idx_wide = WIDE_W'(idx_full);

        head_pop = (state_reg == ENG_IDLE) && active && (skip || m_fall || commit);
        res_push = commit && emit;
        res_item.found       = hit;
        res_item.match_index = hit ? idx_wide[MATCH_IDX_W-1:0] : '0;

        // Register updates
        bi_next        = bi_reg;
        bk_next        = bk_reg;
        work_k_next    = work_k_reg;
        work_c_next    = work_c_reg;
        work_last_next = work_last_reg;
        matched_next   = matched_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;

        if (cfg.rebuild)
        begin
            bi_next = '0;
            bk_next = '0;
        end
        else if (b_step)
        begin
            if (bi_reg == '0)
            begin
                bi_next = LEN_W'(1);
                bk_next = '0;
            end
            else if (b_fall)
            begin
                bk_next = tbl_rd;
            end
            else
            begin
                bk_next = bk_new;
                bi_next = bi_reg + 1'b1;
            end
        end

        if (active && !skip && m_fall)
        begin
            work_k_next    = tbl_rd;
            work_c_next    = c_cur;
            work_last_next = last_cur;
        end
        if (commit)
        begin
            matched_next = k_new;
            pos_next     = pos_sat;
            done_next    = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_BUILD;
            bi_reg        <= '0;
            bk_reg        <= '0;
            work_k_reg    <= '0;
            work_last_reg <= 1'b0;
            matched_reg   <= '0;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bi_reg        <= bi_next;
            bk_reg        <= bk_next;
            work_k_reg    <= work_k_next;
            work_last_reg <= work_last_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_c_reg <= work_c_next;
        if (tbl_we)
        begin
            fail_tbl[tbl_wa[IDX_W-1:0]] <= tbl_wd;
        end
    end

    `KMP_ASSERT_IMP(a_no_result_in_build, state_reg == ENG_BUILD, !res_push,
        "result produced while the failure table is being built")
    `KMP_ASSERT_IMP(a_walk_k_range, state_reg == ENG_WALK,
        LEN_W'(work_k_reg) < cfg.eff_len,
        "fallback walk holds a border outside the pattern")
    `KMP_ASSERT_NXT(a_result_closes_text, res_push, done_reg,
        "text not closed after its result")
    `KMP_ASSERT_IMP(a_pop_only_idle, head_pop, (state_reg == ENG_IDLE) && head_valid,
        "input taken while the engine is busy")

endmodule

[design/kmp_stream_matcher.sv]
// ============================================================================
// KMP stream matcher
// Knuth-Morris-Pratt search of streamed text for a configured pattern.
// ============================================================================
// Channel     | Handshake          | Payload
// ------------+--------------------+----------------------------------------
// text input  | push / full        | text_item (text_byte, first/last flags)
// result      | pop / empty        | result (found, match_index)
// config      | cfg_we             | cfg_index, cfg_data
//
// A text byte takes one comparison in the matcher plus one fallback step
// through the failure table for each mismatch against a nonzero border.
// After reset and after every write to a pattern register the failure table
// is rebuilt while queued bytes wait.
// Input holds four transactions and the result queue two, so either side may
// stall without stopping the other until its queue fills.
// ============================================================================
`timescale 1ns / 1ps

module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = KMP_MAX_PATTERN,
    parameter int POSITION_BITS = KMP_POSITION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              text_item,
    input  logic                  pop,
    output logic                  empty,
    output res_item_t             result,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IN_DEPTH  = 4;
    localparam int RES_DEPTH = 2;

    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] low_reg;
    logic [CFG_DATA_W-1:0] high_reg;
    logic                  known_idx;
    cfg_bus_t              cfg;
    logic [LEN_W-1:0]      len_lo;

    in_item_t  head;
    logic      head_empty, head_pop;
    logic      res_full, res_push;
    res_item_t res_in;

    // A length of zero acts as one; larger values clamp to the table size.
    always_comb
    begin
        len_lo      = (len_reg == '0) ? LEN_W'(1) : len_reg;
        cfg.eff_len = (len_lo > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_lo;
        cfg.pattern = {high_reg, low_reg};
        known_idx   = (cfg_index == REG_PATTERN_LENGTH) || (cfg_index == REG_PATTERN_LOW)
                      || (cfg_index == REG_PATTERN_HIGH);
        cfg.rebuild = cfg_we && known_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_W'(1);
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   high_reg <= cfg_data;
                default:            len_reg  <= len_reg;
            endcase
        end
    end

    kmp_queue #(
        .WIDTH ($bits(in_item_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (text_item),
        .full    (full),
        .pop     (head_pop),
        .rd_data (head),
        .empty   (head_empty)
    );

    kmp_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (!head_empty),
        .head_pop   (head_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_item   (res_in)
    );

    kmp_queue #(
        .WIDTH ($bits(res_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

[tb/kmp_stream_matcher_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// KMP stream matcher testbench
// Streams texts through the matcher and checks every match report against a
// local Knuth-Morris-Pratt search that tracks the pattern registers. Directed
// cases come first, then random phases of texts, with the sender working in
// bursts and the receiver stalling on its own pattern.
// ============================================================================

module kmp_stream_matcher_tb;
    import kmp_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 500000;
    localparam int unsigned DRAIN_CYCLES  = 150;
    localparam int unsigned RANDOM_BYTES  = 1400;
    localparam int unsigned MAX_PAT       = KMP_MAX_PATTERN;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              text_item;
    logic                  pop;
    logic                  empty;
    res_item_t             result;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the matcher state.
    logic [4:0]  pat_len_q;
    logic [63:0] pat_lo_q;
    logic [63:0] pat_hi_q;
    logic [3:0]  fallback [MAX_PAT];
    logic [4:0]  matched_len;
    logic [31:0] next_pos;
    bit          text_closed;

    res_item_t   pending_reports [$];

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned bytes_searched;
    int unsigned bytes_sent;
    int unsigned texts_started;
    int unsigned register_writes;
    int unsigned cycle_count;
    int unsigned burst_left;

    kmp_stream_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .text_item (text_item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned active_length();
        int unsigned m;
        m = pat_len_q;
        if (m < 1)
            m = 1;
        if (m > MAX_PAT)
            m = MAX_PAT;
        return m;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned i);
        int unsigned j;
        j = i % 16;
        if (j < 8)
            return pat_lo_q[j*8 +: 8];
        return pat_hi_q[(j-8)*8 +: 8];
    endfunction

    // Longest proper prefix that is also a suffix, for every pattern prefix.
    function automatic void build_fallback_table();
        int unsigned m;
        int unsigned i;
        int unsigned k;
        m = active_length();
        k = 0;
        for (i = 0; i < MAX_PAT; i++)
            fallback[i] = '0;
        for (i = 1; i < m; i++)
        begin
            while (k > 0 && pattern_at(k) != pattern_at(i))
                k = fallback[(k - 1) % 16];
            if (pattern_at(k) == pattern_at(i))
                k++;
            fallback[i] = 4'(k);
        end
    endfunction

    function automatic void reset_matcher_state();
        pat_len_q   = 5'd1;
        pat_lo_q    = '0;
        pat_hi_q    = '0;
        matched_len = '0;
        next_pos    = '0;
        text_closed = 1'b0;
        build_fallback_table();
    endfunction

    function automatic void apply_register_write(input logic [REG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LENGTH: pat_len_q = data[4:0];
            REG_PATTERN_LOW:    pat_lo_q  = data;
            REG_PATTERN_HIGH:   pat_hi_q  = data;
            default:            return;
        endcase
        register_writes++;
        build_fallback_table();
    endfunction

    // Advances the search by one text byte and queues the report it causes.
    function automatic void scan_text_byte(input in_item_t item);
        int unsigned     m;
        int unsigned     k;
        longint unsigned start;
        res_item_t       rep;
        m = active_length();
        if (item.first_byte)
        begin
            matched_len = '0;
            next_pos    = '0;
            text_closed = 1'b0;
            texts_started++;
        end
        if (text_closed)
            return;
        bytes_searched++;
        k = matched_len;
        // A shorter pattern written mid-text restarts the partial match.
        if (k >= m)
            k = 0;
        while (k > 0 && pattern_at(k) != item.text_byte)
            k = fallback[(k - 1) % 16];
        if (pattern_at(k) == item.text_byte)
            k++;
        if (k == m)
        begin
            start = longint'(next_pos) + 1;
            start = (start >= m) ? start - m : 0;
            rep.found       = 1'b1;
            rep.match_index = start[31:0];
            pending_reports.push_back(rep);
            text_closed = 1'b1;
        end
        else if (item.last_byte)
        begin
            rep = '0;
            pending_reports.push_back(rep);
            text_closed = 1'b1;
        end
        matched_len = 5'(k);
        if (next_pos != '1)
            next_pos = next_pos + 1;
    endfunction

    function automatic void check_report(input res_item_t got);
        res_item_t want;
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected result: found=%0b match_index=%0d",
                     $time, got.found, got.match_index);
            mismatches++;
            return;
        end
        want = pending_reports.pop_front();
        results_checked++;
        if (got.found !== want.found)
        begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, got.found);
            mismatches++;
        end
        if (got.match_index !== want.match_index)
        begin
            $display("%0t: match_index mismatch: expected %0d, actual %0d",
                     $time, want.match_index, got.match_index);
            mismatches++;
        end
    endfunction

    // One process sees every transaction in order: results, writes, text bytes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_report(result);
            if (cfg_we)
                apply_register_write(cfg_index, cfg_data);
            if (push && !full)
            begin
                bytes_sent++;
                scan_text_byte(text_item);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: switches between free flow, random pops, sparse pops and long stalls.
    initial
    begin
        int unsigned mode;
        int unsigned left;
        pop  = 1'b0;
        left = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (left % 16 == 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int unsigned gap;
        in_item_t    item;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        item.text_byte  = b;
        item.first_byte = first;
        item.last_byte  = last;
        @(negedge clk);
        push      <= 1'b1;
        text_item <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Holds the sender until every report is in and the matcher has settled.
    task automatic wait_for_idle();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sends n bytes; pick_pct of the free bytes come from the pattern alphabet.
    task automatic send_text(input int unsigned n, input bit opens, input bit closes,
                             input bit plant, input int unsigned pick_pct);
        int unsigned m;
        int unsigned at;
        int unsigned j;
        logic [7:0]  b;
        m  = active_length();
        at = (plant && n >= m) ? $urandom_range(0, n - m) : n;
        for (j = 0; j < n; j++)
        begin
            if (j >= at && j < at + m)
                b = pattern_at(j - at);
            else if ($urandom_range(0, 99) < pick_pct)
                b = pattern_at($urandom_range(0, m - 1));
            else
                b = 8'($urandom);
            send_byte(b, opens && j == 0, closes && j == n - 1);
        end
    endtask

    task automatic test_before_first_byte();
        // Reset pattern is a single zero byte.
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_length_extremes();
        wait_for_idle();
        write_register(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        write_register(REG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
        write_register(REG_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210);
        // Whole 16-byte pattern, completed on the byte marked last.
        send_text(16, 1'b1, 1'b1, 1'b1, 0);
        wait_for_idle();
        // Length field of zero behaves as a one-byte pattern.
        write_register(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        send_byte(8'hEF, 1'b1, 1'b1);
    endtask

    task automatic test_fallback_steps();
        wait_for_idle();
        write_register(REG_PATTERN_LENGTH, 64'd3);
        write_register(REG_PATTERN_LOW, 64'h0000_0000_0062_6161);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h61, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0, 1'b0);
        send_byte(8'h62, 1'b0, 1'b1);
    endtask

    task automatic test_pattern_change_mid_text();
        wait_for_idle();
        write_register(REG_PATTERN_LENGTH, 64'd4);
        write_register(REG_PATTERN_LOW, 64'h0000_0000_6161_6161);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h61, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0, 1'b0);
        wait_for_idle();
        // Three bytes matched, new length two: the partial match starts over.
        write_register(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h61, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0, 1'b1);
    endtask

    task automatic random_config();
        int unsigned   r;
        int unsigned   i;
        int unsigned   len;
        logic [7:0]    sym_a;
        logic [7:0]    sym_b;
        logic [127:0]  pat;
        logic [63:0]   len_word;
        bit            w_len;
        bit            w_lo;
        bit            w_hi;
        r = $urandom_range(0, 19);
        if (r == 0)
            len = 0;
        else if (r == 1)
            len = MAX_PAT;
        else if (r == 2)
            len = $urandom_range(17, 31);
        else if (r == 3)
            len = 1;
        else if (r < 15)
            len = $urandom_range(2, 6);
        else
            len = $urandom_range(7, 15);
        len_word      = {$urandom, $urandom};
        len_word[4:0] = 5'(len);
        if ($urandom_range(0, 1))
        begin
            // Two-symbol patterns give long fallback chains.
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            for (i = 0; i < 16; i++)
                pat[i*8 +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
        end
        else
            pat = {$urandom, $urandom, $urandom, $urandom};
        w_len = ($urandom_range(0, 3) != 0);
        w_lo  = ($urandom_range(0, 3) != 0);
        w_hi  = 1'($urandom_range(0, 1));
        if (!(w_len || w_lo || w_hi))
            w_len = 1'b1;
        if (w_len)
            write_register(REG_PATTERN_LENGTH, len_word);
        if (w_lo)
            write_register(REG_PATTERN_LOW, pat[63:0]);
        if (w_hi)
            write_register(REG_PATTERN_HIGH, pat[127:64]);
    endtask

    task automatic test_random_texts();
        int unsigned base;
        int unsigned texts;
        int unsigned t;
        int unsigned kind;
        int unsigned n;
        bit          open_text;
        base      = bytes_sent;
        open_text = 1'b0;
        while (bytes_sent - base < RANDOM_BYTES)
        begin
            wait_for_idle();
            random_config();
            if (open_text)
                send_text($urandom_range(1, 12), 1'b0, 1'b1, 1'b1, 70);
            texts = $urandom_range(4, 10);
            for (t = 0; t < texts; t++)
            begin
                kind = $urandom_range(0, 9);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 20);
                if (kind == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
                else if (kind == 1)
                    send_text(n, 1'b1, 1'b1, 1'b0, 0);
                else
                    send_text(n, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 70);
            end
            // Sometimes leave a text open so the next write lands mid-text.
            open_text = ($urandom_range(0, 3) == 0);
            if (open_text)
                send_text($urandom_range(1, 8), 1'b1, 1'b0, 1'b0, 70);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        text_item       = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_PATTERN_LENGTH;
        cfg_data        = '0;
        mismatches      = 0;
        results_checked = 0;
        bytes_searched  = 0;
        bytes_sent      = 0;
        texts_started   = 0;
        register_writes = 0;
        cycle_count     = 0;
        burst_left      = 0;
        reset_matcher_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_before_first_byte();
        test_length_extremes();
        test_fallback_steps();
        test_pattern_change_mid_text();
        test_random_texts();
        wait_for_idle();

        $display("Sent %0d text bytes, searched %0d of them in %0d texts, checked %0d reports.",
                 bytes_sent, bytes_searched, texts_started, results_checked);
        $display("Made %0d pattern register writes, lengths 0 to 31, some mid-text.",
                 register_writes);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
